>>> design/maze_grid_query_engine_top_assert.svh
// Assertion macros for the maze grid query engine.
// Included by the top level; relies on clk and rst_n in scope.
`ifndef MAZE_GRID_QUERY_ENGINE_TOP_ASSERT_SVH
`define MAZE_GRID_QUERY_ENGINE_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define MGQ_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mgq check failed");
// Implication checked in the cycle after the condition.
`define MGQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mgq check failed");
`endif

>>> design/mgq_pkg.sv
// Package for the maze grid query engine: widths, codes and helper types.
// No dependencies.
package mgq_pkg;
  localparam int MaxRows  = 64;
  localparam int MaxCols  = 64;
  localparam int CellBits = 16;
  localparam int RowW     = $clog2(MaxRows);
  localparam int ColW     = $clog2(MaxCols);
  localparam int AddrW    = RowW + ColW;
  localparam int NumCells = MaxRows * MaxCols;
  localparam int CfgW     = 7;
  localparam int QDepth   = 2;

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0, FN_TYPE = 3'd1, FN_WHITE = 3'd2, FN_GREY = 3'd3,
    FN_BLACK = 3'd4, FN_BREAK = 3'd5, FN_ROOM = 3'd6, FN_NOP = 3'd7
  } func_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OFF = 2'd1;
  localparam logic [1:0] ST_NOT_GREY = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Classified command word passed from front end to back end.
  typedef struct packed {
    func_t             func;
    logic              off;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   trow;
    logic [ColW-1:0]   tcol;
    logic [15:0]       value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] answer;
  } res_t;
endpackage

>>> design/mgq_if.sv
// Valid/ready channel interfaces for the maze grid query engine.
// Depends on mgq_pkg.
interface mgq_in_if (input logic clk);
  import mgq_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  row;
  logic [5:0]  column;
  logic [5:0]  target_row;
  logic [5:0]  target_column;
  logic signed [15:0] cell_value;
  modport source (output valid, func, row, column, target_row, target_column, cell_value,
                  input ready);
  modport sink (input valid, func, row, column, target_row, target_column, cell_value,
                output ready);
endinterface

interface mgq_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [15:0] answer;
  modport source (output valid, status, answer, input ready);
  modport sink (input valid, status, answer, output ready);
endinterface

interface mgq_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [6:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/mgq_front.sv
// Front end: accepts input words, checks bounds and queues classified commands.
// Depends on mgq_pkg and the channel interfaces.
module mgq_front (
  input  logic              clk,
  input  logic              rst_n,
  mgq_in_if.sink            in_ch,
  input  logic [6:0]        rows_eff,
  input  logic [6:0]        cols_eff,
  output logic              q_valid,
  output mgq_pkg::cmd_t     q_cmd,
  input  logic              q_pop,
  output logic              q_empty
);
  import mgq_pkg::*;

  cmd_t          q_mem_r [QDepth];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wp_r, rp_r;
  cmd_t          cmd_in;
  logic          push;
  logic          off_a, off_b;

  // Classify the incoming word.
  always_comb begin
    off_a = ({1'b0, in_ch.row} >= rows_eff) || ({1'b0, in_ch.column} >= cols_eff);
    off_b = ({1'b0, in_ch.target_row} >= rows_eff) ||
            ({1'b0, in_ch.target_column} >= cols_eff);
    cmd_in.func  = func_t'(in_ch.func);
    cmd_in.off   = (in_ch.func != FN_NOP) &&
                   (off_a || (in_ch.func == FN_ROOM && off_b));
    cmd_in.row   = in_ch.row;
    cmd_in.col   = in_ch.column;
    cmd_in.trow  = in_ch.target_row;
    cmd_in.tcol  = in_ch.target_column;
    cmd_in.value = in_ch.cell_value;
  end

  assign in_ch.ready = (cnt_r != 2'(QDepth));
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_empty = (cnt_r == 2'd0);
  assign q_cmd   = q_mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= cmd_in;
  end

  // Queue pointers and fill count.
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end
endmodule

>>> design/mgq_back.sv
// Back end: grid memory, visited bitmap, search stack and query sequencer.
// Depends on mgq_pkg and the output channel interface.
module mgq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        rows_eff,
  input  logic [6:0]        cols_eff,
  input  logic              q_valid,
  input  mgq_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              busy,
  mgq_out_if.source         out_ch
);
  import mgq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_RDW   = 10'b0000001000,
    S_EVAL  = 10'b0000010000,
    S_POP   = 10'b0000100000,
    S_POPW  = 10'b0001000000,
    S_NB    = 10'b0010000000,
    S_NBW   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  logic [CellBits-1:0] grid_mem [NumCells];
  logic                vis_mem  [NumCells];
  logic [AddrW-1:0]    stk_mem  [NumCells];

  state_t            st_r;
  cmd_t              cmd_r;
  logic [2:0]        nb_r;
  logic [AddrW:0]    sp_r;
  logic [AddrW:0]    clr_r;
  logic [AddrW-1:0]  cur_r;
  logic [CellBits-1:0] gq_r;
  logic              vq_r;
  logic [AddrW-1:0]  stq_r;
  logic              flag_r;
  logic [1:0]        wcnt_r;
  logic [AddrW-1:0]  cand_r;
  logic              cand_ok_r;
  res_t              res_r;
  logic              out_valid_r;
  logic              tgt_vis_r;

  logic [AddrW-1:0]  g_addr, v_addr;
  logic              g_we, v_we;
  logic [CellBits-1:0] g_wd;
  logic              v_wd;
  logic [AddrW-1:0]  base_a, tgt_a;
  logic [RowW:0]     nr;
  logic [ColW:0]     nc;
  logic              nb_on;
  logic [AddrW-1:0]  nb_a;
  logic signed [CellBits-1:0] gs;
  logic              is_white, is_grey, is_black, hit;
  logic              nbok_l, wok_l, nbon_d1, nbon_d2;

  assign base_a = {cmd_r.row, cmd_r.col};
  assign tgt_a  = {cmd_r.trow, cmd_r.tcol};
  assign gs     = gq_r;
  assign is_white = (gs == '0);
  assign is_grey  = (gs > 0);
  assign is_black = (gs == '1);

  // Neighbour coordinate for step nb_r of the current base cell.
  always_comb begin
    logic [RowW-1:0] br;
    logic [ColW-1:0] bc;
    br = (st_r == S_RD || st_r == S_RDW || st_r == S_EVAL) && cmd_r.func != FN_ROOM
         ? cmd_r.row : cur_r[AddrW-1:ColW];
    bc = (st_r == S_RD || st_r == S_RDW || st_r == S_EVAL) && cmd_r.func != FN_ROOM
         ? cmd_r.col : cur_r[ColW-1:0];
    case (nb_r)
      3'd1: begin nr = {1'b0, br} + 1'b1; nc = {1'b0, bc}; end
      3'd2: begin nr = {1'b0, br}; nc = {1'b0, bc} + 1'b1; end
      3'd3: begin nr = {1'b0, br} - 1'b1; nc = {1'b0, bc}; end
      3'd4: begin nr = {1'b0, br}; nc = {1'b0, bc} - 1'b1; end
      default: begin nr = {1'b0, br}; nc = {1'b0, bc}; end
    endcase
    nb_on = !nr[RowW] && !nc[ColW] && ({1'b0, nr} < {1'b0, rows_eff}) &&
            ({1'b0, nc} < {1'b0, cols_eff});
    nb_a  = {nr[RowW-1:0], nc[ColW-1:0]};
  end

  // Memory ports.
  always_comb begin
    g_we   = (st_r == S_IDLE) && q_valid && !out_valid_r && !q_cmd.off &&
             q_cmd.func == FN_WRITE;
    g_addr = g_we ? {q_cmd.row, q_cmd.col} : nb_a;
    g_wd   = q_cmd.value[CellBits-1:0];
    v_we   = 1'b0;
    v_wd   = 1'b0;
    v_addr = nb_a;
    if (st_r == S_CLEAR) begin
      v_we = 1'b1; v_addr = clr_r[AddrW-1:0];
      v_wd = (clr_r[AddrW-1:0] == base_a);
    end else if (st_r == S_NBW && cand_ok_r) begin
      v_we = 1'b1; v_addr = cand_r; v_wd = 1'b1;
    end else if (st_r == S_POP || st_r == S_POPW) begin
      v_addr = tgt_a;
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_addr] <= g_wd;
    gq_r <= grid_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vis_mem[v_addr] <= v_wd;
    vq_r <= vis_mem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR && clr_r == '0) stk_mem[0] <= base_a;
    else if (st_r == S_NBW && cand_ok_r) stk_mem[sp_r[AddrW-1:0]] <= cand_r;
    stq_r <= stk_mem[sp_r[AddrW-1:0] - 1'b1];
  end

  // Match test for the current query kind.
  always_comb begin
    case (cmd_r.func)
      FN_WHITE: hit = is_white;
      FN_GREY:  hit = is_grey;
      FN_BLACK: hit = is_black;
      default:  hit = is_white;
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && q_valid && !out_valid_r;
  assign busy  = (st_r != S_IDLE) || out_valid_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = res_r.status;
  assign out_ch.answer = res_r.answer;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid_r <= 1'b0;
      nb_r <= '0; sp_r <= '0; clr_r <= '0; wcnt_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            nb_r <= '0; flag_r <= 1'b0;
            if (q_cmd.off) begin
              res_r <= '{ST_OFF, 16'd0}; out_valid_r <= 1'b1;
            end else if (q_cmd.func == FN_WRITE || q_cmd.func == FN_NOP) begin
              res_r <= '{ST_OK, 16'd0}; out_valid_r <= 1'b1;
            end else if (q_cmd.func == FN_ROOM) begin
              if ({q_cmd.row, q_cmd.col} == {q_cmd.trow, q_cmd.tcol}) begin
                res_r <= '{ST_OK, 16'd1}; out_valid_r <= 1'b1;
              end else begin
                clr_r <= '0; st_r <= S_CLEAR;
              end
            end else begin
              st_r <= S_RD;
            end
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AddrW+1)'(NumCells - 1)) begin
            sp_r <= (AddrW+1)'(1); st_r <= S_POP;
          end
        end
        // Simple queries: read base cell then up to four neighbours.
        S_RD: st_r <= S_RDW;
        S_RDW: st_r <= S_EVAL;
        S_EVAL: begin
          if (nb_r == 3'd0) begin
            if (cmd_r.func == FN_TYPE) begin
              res_r <= '{ST_OK, 16'($signed(gs))}; out_valid_r <= 1'b1; st_r <= S_DONE;
            end else if (cmd_r.func == FN_BREAK && !is_grey) begin
              res_r <= '{ST_NOT_GREY, 16'd0}; out_valid_r <= 1'b1; st_r <= S_DONE;
            end else begin
              nb_r <= 3'd1; st_r <= S_RD;
            end
          end else begin
            if (cmd_r.func == FN_BREAK) begin
              // Bits: below, right, above, left white flags in wcnt/flag.
              case (nb_r)
                3'd1: wcnt_r[0] <= wok_l;
                3'd2: wcnt_r[1] <= wok_l;
                3'd3: flag_r <= flag_r || (wcnt_r[0] && wok_l);
                default: flag_r <= flag_r || (wcnt_r[1] && wok_l);
              endcase
            end else begin
              flag_r <= flag_r || (nbok_l && hit);
            end
            if (nb_r == 3'd4) st_r <= S_DONE;
            else begin nb_r <= nb_r + 1'b1; st_r <= S_RD; end
          end
        end
        S_DONE: begin
          if (!out_valid_r) begin
            res_r <= '{ST_OK, {15'd0, flag_r}}; out_valid_r <= 1'b1;
          end
          st_r <= S_IDLE;
        end
        // Flood fill: pop, then test four neighbours.
        S_POP: begin
          if (sp_r == '0) begin
            res_r <= '{ST_OK, 16'd0}; out_valid_r <= 1'b1; st_r <= S_IDLE;
          end else st_r <= S_POPW;
        end
        S_POPW: begin
          if (vq_r) begin
            res_r <= '{ST_OK, 16'd1}; out_valid_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            cur_r <= stq_r; sp_r <= sp_r - 1'b1; nb_r <= 3'd1; st_r <= S_NB;
          end
        end
        S_NB: begin
          cand_r <= nb_a; cand_ok_r <= 1'b0; tgt_vis_r <= nb_on; st_r <= S_NBW;
          wcnt_r <= '0;
        end
        S_NBW: begin
          if (wcnt_r == 2'd0) begin
            wcnt_r <= 2'd1;
            cand_ok_r <= 1'b0;
          end else if (wcnt_r == 2'd1) begin
            wcnt_r <= 2'd2;
            cand_ok_r <= tgt_vis_r && is_white && !vq_r;
          end else begin
            if (cand_ok_r) sp_r <= sp_r + 1'b1;
            cand_ok_r <= 1'b0;
            if (nb_r == 3'd4) st_r <= S_POP;
            else begin nb_r <= nb_r + 1'b1; st_r <= S_NB; end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Registered on-board flag for the neighbour being evaluated.
  always_ff @(posedge clk) begin
    nbon_d1 <= nb_on;
    nbon_d2 <= nbon_d1;
  end
  assign nbok_l = nbon_d2;
  assign wok_l  = nbon_d2 && is_white;
endmodule

>>> design/maze_grid_query_engine_top.sv
// Maze grid query engine top level: configuration registers, front end, back end.
// Depends on mgq_pkg, the channel interfaces, mgq_front, mgq_back and the assert header.
//
// Each word yields one result, and the back end takes the next word only once the
// previous result has been accepted. Writes and no-ops are answered directly; a type
// query reads the cell itself; neighbour and breakable queries read the cell itself
// and then its four neighbours (a breakable query stops early if the cell is not
// grey). A same-room query first sweeps the visited bitmap, then runs a depth-first
// flood fill that pops one cell at a time and tests its four neighbours. Up to two
// words queue ahead of the back end. Configuration is always accepted, but must only
// be written while no word is in flight.
module maze_grid_query_engine_top (
  input logic clk,
  input logic rst_n,
  mgq_in_if.sink    in_ch,
  mgq_out_if.source out_ch,
  mgq_cfg_if.sink   cfg_ch
);
  import mgq_pkg::*;
  `include "maze_grid_query_engine_top_assert.svh"

  logic [CfgW-1:0] rows_r, cols_r;
  logic [6:0]      rows_eff, cols_eff;
  logic            q_valid, q_pop, q_empty, busy;
  cmd_t            q_cmd;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'(MaxRows);
      cols_r <= 7'(MaxCols);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ROWS: rows_r <= cfg_ch.data;
        default:  cols_r <= cfg_ch.data;
      endcase
    end
  end

  assign rows_eff = (rows_r > 7'(MaxRows)) ? 7'(MaxRows) : rows_r;
  assign cols_eff = (cols_r > 7'(MaxCols)) ? 7'(MaxCols) : cols_r;

  mgq_front u_front (
    .clk, .rst_n, .in_ch, .rows_eff, .cols_eff,
    .q_valid, .q_cmd, .q_pop, .q_empty
  );

  mgq_back u_back (
    .clk, .rst_n, .rows_eff, .cols_eff,
    .q_valid, .q_cmd, .q_pop, .busy, .out_ch
  );

  `MGQ_ASSERT_IMPL(a_pop_needs_data, q_pop, q_valid)
  `MGQ_ASSERT_NEXT(a_pop_busy, q_pop, busy)
  `MGQ_ASSERT_IMPL(a_empty_consistent, q_empty, !q_valid)
endmodule

>>> bench/maze_grid_query_engine_top_tb.sv
// Self-checking testbench for the maze grid query engine top level.
// Depends on mgq_pkg, the channel interfaces in mgq_if.sv and the block itself.
`timescale 1ns / 100ps

module maze_grid_query_engine_top_tb;
  import mgq_pkg::*;

  typedef struct {
    func_t             func;
    logic [5:0]        row;
    logic [5:0]        col;
    logic [5:0]        trow;
    logic [5:0]        tcol;
    logic signed [15:0] value;
  } query_word_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] answer;
  } query_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mgq_in_if  in_ch (clk);
  mgq_out_if out_ch (clk);
  mgq_cfg_if cfg_ch (clk);

  maze_grid_query_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  query_word_t   pending_words[$];
  query_result_t expected_results[$];
  int            errors = 0;
  bit            out_hold = 1'b0;
  bit            no_idle = 1'b0;

  // Shadow copy of the grid and the registers, as the block should hold them.
  logic signed [15:0] shadow_grid [NumCells];
  logic [6:0]         shadow_rows = 7'd64;
  logic [6:0]         shadow_cols = 7'd64;
  // Cells the generator has written under the current board size.
  bit                 gen_written [NumCells];
  int                 gen_rows;
  int                 gen_cols;

  function automatic int eff_rows();
    return (shadow_rows > MaxRows) ? MaxRows : int'(shadow_rows);
  endfunction

  function automatic int eff_cols();
    return (shadow_cols > MaxCols) ? MaxCols : int'(shadow_cols);
  endfunction

  function automatic bit on_board(int r, int c);
    return r >= 0 && c >= 0 && r < eff_rows() && c < eff_cols();
  endfunction

  // Kind: white, grey or black, picked by the neighbour query code.
  function automatic bit cell_is(int r, int c, func_t kind);
    logic signed [15:0] v;
    if (!on_board(r, c)) return 1'b0;
    v = shadow_grid[r * MaxCols + c];
    case (kind)
      FN_WHITE: return v == 0;
      FN_GREY:  return v >= 1;
      default:  return v == -1;
    endcase
  endfunction

  // Reachability through white cells; the start cell is always entered.
  function automatic bit rooms_joined(int r, int c, int tr, int tc);
    bit seen [NumCells];
    int stack[$];
    int idx, cr, cc, nr, nc;
    idx = r * MaxCols + c;
    seen[idx] = 1'b1;
    stack.push_back(idx);
    while (stack.size() > 0 && !seen[tr * MaxCols + tc]) begin
      idx = stack.pop_back();
      cr = idx / MaxCols;
      cc = idx % MaxCols;
      for (int d = 0; d < 4; d++) begin
        nr = cr + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
        nc = cc + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
        if (cell_is(nr, nc, FN_WHITE) && !seen[nr * MaxCols + nc]) begin
          seen[nr * MaxCols + nc] = 1'b1;
          stack.push_back(nr * MaxCols + nc);
        end
      end
    end
    return seen[tr * MaxCols + tc];
  endfunction

  // Expected result of one word; writes update the shadow grid.
  function automatic query_result_t grid_answer(query_word_t w);
    query_result_t res;
    int r, c;
    r = int'(w.row);
    c = int'(w.col);
    res.status = ST_OK;
    res.answer = '0;
    if (w.func == FN_NOP) begin
      // Nothing happens.
    end else if (!on_board(r, c)) begin
      res.status = ST_OFF;
    end else begin
      case (w.func)
        FN_WRITE: shadow_grid[r * MaxCols + c] = w.value;
        FN_TYPE:  res.answer = shadow_grid[r * MaxCols + c];
        FN_WHITE, FN_GREY, FN_BLACK:
          res.answer = 16'(cell_is(r + 1, c, w.func) || cell_is(r, c + 1, w.func) ||
                           cell_is(r - 1, c, w.func) || cell_is(r, c - 1, w.func));
        FN_BREAK: begin
          if (shadow_grid[r * MaxCols + c] <= 0)
            res.status = ST_NOT_GREY;
          else
            res.answer = 16'((cell_is(r - 1, c, FN_WHITE) && cell_is(r + 1, c, FN_WHITE)) ||
                             (cell_is(r, c - 1, FN_WHITE) && cell_is(r, c + 1, FN_WHITE)));
        end
        default: begin
          if (!on_board(int'(w.trow), int'(w.tcol)))
            res.status = ST_OFF;
          else
            res.answer = 16'(rooms_joined(r, c, int'(w.trow), int'(w.tcol)));
        end
      endcase
    end
    return res;
  endfunction

  // Input driver: offers queued words, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 29)) begin
        query_word_t w;
        w = pending_words.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.func          <= w.func;
        in_ch.row           <= w.row;
        in_ch.column        <= w.col;
        in_ch.target_row    <= w.trow;
        in_ch.target_column <= w.tcol;
        in_ch.cell_value    <= w.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready, with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !out_hold && (no_idle || $urandom_range(99) >= 29);
  end

  // Prediction on each accepted word and register write.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      query_word_t w;
      w.func  = func_t'(in_ch.func);
      w.row   = in_ch.row;
      w.col   = in_ch.column;
      w.trow  = in_ch.target_row;
      w.tcol  = in_ch.target_column;
      w.value = in_ch.cell_value;
      expected_results.push_back(grid_answer(w));
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_ROWS) shadow_rows <= cfg_ch.data;
      else shadow_cols <= cfg_ch.data;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation: status %0d answer %0d",
               out_ch.status, out_ch.answer);
        errors++;
      end else begin
        query_result_t e;
        e = expected_results.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.answer !== e.answer) begin
          $error("answer: expected %0d, actual %0d", e.answer, out_ch.answer);
          errors++;
        end
      end
    end
  end

  task automatic push_word(func_t f, int r, int c, int tr, int tc, int v);
    query_word_t w;
    w.func  = f;
    w.row   = 6'(r);
    w.col   = 6'(c);
    w.trow  = 6'(tr);
    w.tcol  = 6'(tc);
    w.value = 16'(v);
    if (f == FN_WRITE && r < gen_rows && c < gen_cols) gen_written[r * MaxCols + c] = 1'b1;
    pending_words.push_back(w);
  endtask

  // Wait until every queued word has been accepted and answered.
  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= 7'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int rand_cell();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 70) return -1;
    if (p < 95) return int'($urandom_range(32767, 1));
    return int'($urandom_range(32767)) - 32768;
  endfunction

  function automatic int rand_coord(int lim);
    if (lim > 0 && $urandom_range(99) < 85) return int'($urandom_range(lim - 1));
    return int'($urandom_range(63));
  endfunction

  // Set the board size and, if fill is set, write every on-board cell not yet written.
  task automatic resize_board(int rows, int cols, bit fill);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    gen_rows = (rows > MaxRows) ? MaxRows : rows;
    gen_cols = (cols > MaxCols) ? MaxCols : cols;
    if (fill)
      for (int r = 0; r < gen_rows; r++)
        for (int c = 0; c < gen_cols; c++)
          if (!gen_written[r * MaxCols + c]) push_word(FN_WRITE, r, c, 0, 0, rand_cell());
  endtask

  // Random words; with few_rooms set, room queries are replaced by type queries.
  task automatic random_words(int count, bit few_rooms);
    int p;
    func_t f;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 35) f = FN_WRITE;
      else if (p < 50) f = few_rooms ? FN_TYPE : FN_ROOM;
      else if (p < 97) f = func_t'($urandom_range(5, 1));
      else f = FN_NOP;
      push_word(f, rand_coord(gen_rows), rand_coord(gen_cols), rand_coord(gen_rows),
                rand_coord(gen_cols), rand_cell());
    end
  endtask

  // Receiver hold-off long enough to back up the input, then a stretch with no idling.
  initial begin
    wait (rst_n);
    repeat (30) @(posedge clk);
    out_hold = 1'b1;
    repeat (400) @(posedge clk);
    out_hold = 1'b0;
    repeat (1200) @(posedge clk);
    no_idle = 1'b1;
    repeat (800) @(posedge clk);
    no_idle = 1'b0;
  end

  // Stimulus sequence and final verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_NOP;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.target_row = '0;
    in_ch.target_column = '0;
    in_ch.cell_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ROWS;
    cfg_ch.data = '0;
    gen_rows = MaxRows;
    gen_cols = MaxCols;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a 4 x 5 board with a hand-drawn layout.
    resize_board(4, 5, 1'b0);
    begin
      automatic int layout [4][5] = '{'{0, 0, 0, -1, 0},
                                      '{0, 9, -1, 32767, -1},
                                      '{-32768, 0, 5, 0, 0},
                                      '{-1, -1, -1, 0, 4}};
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 5; c++) push_word(FN_WRITE, r, c, 0, 0, layout[r][c]);
    end
    push_word(FN_TYPE, 2, 0, 0, 0, 0);        // most negative value read back
    push_word(FN_TYPE, 1, 3, 0, 0, 0);        // largest grey cost
    push_word(FN_WHITE, 3, 0, 0, 0, 0);
    push_word(FN_GREY, 0, 4, 0, 0, 0);
    push_word(FN_BLACK, 0, 0, 0, 0, 0);
    push_word(FN_BLACK, 3, 4, 0, 0, 0);       // corner, two neighbours off board
    push_word(FN_BREAK, 1, 1, 0, 0, 0);       // white above and below
    push_word(FN_BREAK, 2, 2, 0, 0, 0);       // white left and right
    push_word(FN_BREAK, 1, 3, 0, 0, 0);
    push_word(FN_BREAK, 3, 4, 0, 0, 0);       // edge cell, partner off board
    push_word(FN_BREAK, 0, 0, 0, 0, 0);       // white cell is not grey
    push_word(FN_BREAK, 2, 0, 0, 0, 0);       // value below black is not grey
    push_word(FN_TYPE, 4, 0, 0, 0, 0);        // row off board
    push_word(FN_WRITE, 0, 5, 0, 0, 7);       // write off board is dropped
    push_word(FN_NOP, 63, 63, 63, 63, -1);
    push_word(FN_ROOM, 0, 0, 2, 4, 0);
    push_word(FN_ROOM, 3, 0, 3, 0, 0);        // same cell, black
    push_word(FN_ROOM, 2, 2, 2, 3, 0);        // grey start, white target
    push_word(FN_ROOM, 2, 2, 1, 1, 0);        // grey target other than start
    push_word(FN_ROOM, 0, 0, 63, 63, 0);      // target off board
    push_word(FN_ROOM, 5, 1, 0, 0, 0);        // start off board
    push_word(FN_WRITE, 0, 0, 0, 0, 32767);
    push_word(FN_TYPE, 0, 0, 0, 0, 0);
    drain();

    // Main random part on a 5 x 6 board, with one full pause midway.
    resize_board(5, 6, 1'b1);
    random_words(18, 1'b0);
    drain();
    random_words(18, 1'b0);
    drain();

    // A single row.
    resize_board(1, 8, 1'b1);
    random_words(6, 1'b0);
    drain();

    // Empty board: every cell is off board.
    resize_board(0, 0, 1'b0);
    random_words(5, 1'b0);
    drain();

    // Oversized register values saturate to the full grid; only the far corner is used.
    resize_board(127, 127, 1'b0);
    push_word(FN_WRITE, 63, 63, 0, 0, 5);
    push_word(FN_WRITE, 62, 63, 0, 0, -1);
    push_word(FN_WRITE, 63, 62, 0, 0, -1);
    push_word(FN_TYPE, 63, 63, 0, 0, 0);
    push_word(FN_BLACK, 63, 63, 0, 0, 0);
    push_word(FN_ROOM, 63, 63, 0, 0, 0);      // start walled in by black cells
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
